>>> hdl/osc_pkg.sv
package osc_pkg;

    localparam int TABLE_DEPTH_DEF = 256;
    localparam int PHASE_WIDTH_DEF = 32;
    localparam int STATE_WIDTH_DEF = 32;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 32;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_PHASE_STEP = 2'd0,
        REG_CUTOFF     = 2'd1,
        REG_RESONANCE  = 2'd2
    } cfg_reg_t;

    localparam logic [CFG_DATA_W-1:0] PHASE_STEP_RST = 32'd92386532;

    // pi/2 in Q2.30
    localparam longint HALF_PI_Q30 = 64'd1686629713;

    // harmonic weights 105/35/21/15 = 525 * (1, 1/3, 1/5, 1/7) / 5
    localparam logic [7:0] HARM_WEIGHT [4] = '{8'd105, 8'd35, 8'd21, 8'd15};
    localparam int ACC_W     = 24;
    localparam int DIVISOR   = 525;
    localparam int DIV_ROUND = 262;
    localparam int REM_W     = 10;

    localparam longint TAYLOR_DIV [7] = '{64'd6, 64'd20, 64'd42, 64'd72, 64'd110,
                                          64'd156, 64'd210};

    typedef struct packed {
        logic start;
        logic shift14;
    } mul_cmd_t;

    // sine of a Q2.30 angle in [0, pi/2), scaled to 32767, eight Taylor terms
    function automatic logic [15:0] sine_q15(longint x);
        longint term;
        longint sum;
        longint v;
        term = x;
        sum  = x;
        for (int k = 0; k < 7; k++)
        begin
            term = (term * x) >>> 30;
            term = (term * x) >>> 30;
            term = term / TAYLOR_DIV[k];
            if ((k & 1) == 0)
                sum = sum - term;
            else
                sum = sum + term;
        end
        if (sum < 0)
            sum = 0;
        v = (sum * 64'd32767 + (64'd1 <<< 29)) >>> 30;
        if (v > 64'd32767)
            v = 64'd32767;
        return v[15:0];
    endfunction

endpackage

>>> hdl/osc_ifs.sv
interface osc_tick_if;
    logic valid;
    logic ready;
    logic gate;
    modport source (output valid, output gate, input ready);
    modport sink (input valid, input gate, output ready);
endinterface

interface osc_result_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] sine_sample;
    logic signed [17:0] square_sample;
    modport source (output valid, output sine_sample, output square_sample, input ready);
    modport sink (input valid, input sine_sample, input square_sample, output ready);
endinterface

interface osc_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [osc_pkg::CFG_INDEX_W-1:0]    index;
    logic [osc_pkg::CFG_DATA_W-1:0]     data;
    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

>>> hdl/oscillator_with_resonant_lowpass.sv
// From an accepted tick beat to its result beat: 4 table lookups, a bit-serial divide over
// STATE_WIDTH + 7 numerator bits, then three bit-serial coefficient multiplies over 16
// multiplier bits each, all in sequence; write-back waits for a free output slot.
// A new tick is taken only when idle.
// Reset (async, active low) clears phase and filter stages, loads register defaults.
// The sine table is a constant; no clearing pass is needed.
module oscillator_with_resonant_lowpass #(
    parameter int TABLE_DEPTH = osc_pkg::TABLE_DEPTH_DEF,
    parameter int PHASE_WIDTH = osc_pkg::PHASE_WIDTH_DEF,
    parameter int STATE_WIDTH = osc_pkg::STATE_WIDTH_DEF
) (
    input logic          clk,
    input logic          rst_n,
    osc_tick_if.sink     tick,
    osc_result_if.source result,
    osc_cfg_if.sink      cfg
);

    localparam int SW  = STATE_WIDTH;
    localparam int WW  = SW + 6;
    localparam int NW  = SW + 7;
    localparam int AW  = osc_pkg::ACC_W;
    localparam int SHL = SW - 17;

    localparam logic signed [WW-1:0] SMAX_W = {{(WW-SW+1){1'b0}}, {(SW-1){1'b1}}};
    localparam logic signed [WW-1:0] SMIN_W = {{(WW-SW+1){1'b1}}, {(SW-1){1'b0}}};

    typedef enum logic [3:0] {
        S_IDLE,
        S_LOOK,
        S_DIV_GO,
        S_DIV_WAIT,
        S_MR_GO,
        S_MR_WAIT,
        S_M1_GO,
        S_M1_WAIT,
        S_M2_GO,
        S_M2_WAIT,
        S_WB
    } state_t;

    state_t                  state_reg;
    logic [31:0]             step_reg;
    logic [15:0]             cutoff_reg;
    logic [15:0]             res_reg;
    logic [PHASE_WIDTH-1:0]  phase_reg;
    logic [PHASE_WIDTH-1:0]  mult_reg;
    logic [1:0]              k_reg;
    logic signed [AW-1:0]    acc_reg;
    logic signed [15:0]      s1_reg;
    logic signed [WW-1:0]    x_reg;
    logic signed [WW-1:0]    d_reg;
    logic signed [SW-1:0]    stage1_reg;
    logic signed [SW-1:0]    stage2_reg;
    logic                    gate_reg;
    logic                    out_valid_reg;
    logic signed [15:0]      out_sine_reg;
    logic signed [17:0]      out_sq_reg;

    logic [PHASE_WIDTH-1:0]  phase_next;
    logic signed [15:0]      s_look;
    logic signed [AW-1:0]    s_ext;
    logic signed [AW-1:0]    w_ext;
    logic signed [AW-1:0]    acc_next;
    logic [AW-1:0]           acc_mag;
    logic [NW-1:0]           num;
    logic [NW-1:0]           quot;
    logic                    div_done;
    logic signed [WW-1:0]    x_next;
    logic signed [WW-1:0]    stage1_w;
    logic signed [WW-1:0]    stage2_w;
    logic signed [WW-1:0]    diff12;
    osc_pkg::mul_cmd_t       mul_cmd;
    logic signed [WW-1:0]    mul_a;
    logic [15:0]             mul_b;
    logic signed [WW-1:0]    mul_p;
    logic                    mul_done;
    logic signed [WW-1:0]    d_next;
    logic                    tick_beat;
    logic                    wb_fire;
    logic                    out_valid_next;

    function automatic logic signed [SW-1:0] clamp(logic signed [WW-1:0] v);
        if (v > SMAX_W)
            return SMAX_W[SW-1:0];
        else if (v < SMIN_W)
            return SMIN_W[SW-1:0];
        else
            return v[SW-1:0];
    endfunction

    osc_lookup #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .PHASE_WIDTH (PHASE_WIDTH)
    ) u_lookup (
        .phase (mult_reg),
        .sine  (s_look)
    );

    osc_div #(
        .NW (NW)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (state_reg == S_DIV_GO),
        .num   (num),
        .quot  (quot),
        .done  (div_done)
    );

    osc_sermul #(
        .WW (WW)
    ) u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (mul_cmd),
        .a     (mul_a),
        .b     (mul_b),
        .p     (mul_p),
        .done  (mul_done)
    );

    assign tick_beat  = tick.valid && tick.ready;
    assign phase_next = phase_reg + step_reg[PHASE_WIDTH-1:0];

    // harmonic n reads at n*phase; mult_reg steps by 2*phase per lookup
    assign s_ext    = AW'(s_look);
    assign w_ext    = $signed({{(AW-8){1'b0}}, osc_pkg::HARM_WEIGHT[k_reg]});
    assign acc_next = acc_reg + s_ext * w_ext;

    assign acc_mag = acc_reg[AW-1] ? (~acc_reg + 1'b1) : acc_reg;
    assign num     = {1'b0, acc_mag[AW-2:0], {SHL{1'b0}}} + NW'(osc_pkg::DIV_ROUND);
    assign x_next  = acc_reg[AW-1] ? -$signed(quot[WW-1:0]) : $signed(quot[WW-1:0]);

    assign stage1_w = WW'(stage1_reg);
    assign stage2_w = WW'(stage2_reg);
    assign diff12   = stage1_w - stage2_w;
    assign d_next   = x_reg - stage1_w + mul_p;

    assign mul_cmd.start   = (state_reg == S_MR_GO) || (state_reg == S_M1_GO)
                             || (state_reg == S_M2_GO);
    assign mul_cmd.shift14 = (state_reg == S_MR_GO);
    assign mul_a           = (state_reg == S_M1_GO) ? d_reg : diff12;
    assign mul_b           = (state_reg == S_MR_GO) ? res_reg : cutoff_reg;

    // output slot loads when empty or draining this cycle
    assign wb_fire        = (state_reg == S_WB) && (!out_valid_reg || result.ready);
    assign out_valid_next = wb_fire ? 1'b1
                          : ((out_valid_reg && result.ready) ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            step_reg      <= osc_pkg::PHASE_STEP_RST;
            cutoff_reg    <= '0;
            res_reg       <= '0;
            phase_reg     <= '0;
            mult_reg      <= '0;
            k_reg         <= '0;
            acc_reg       <= '0;
            s1_reg        <= '0;
            x_reg         <= '0;
            d_reg         <= '0;
            stage1_reg    <= '0;
            stage2_reg    <= '0;
            gate_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            out_sine_reg  <= '0;
            out_sq_reg    <= '0;
        end
        else
        begin
            if (cfg.valid)
            begin
                case (cfg.index)
                    osc_pkg::REG_PHASE_STEP: step_reg   <= cfg.data;
                    osc_pkg::REG_CUTOFF:     cutoff_reg <= cfg.data[15:0];
                    osc_pkg::REG_RESONANCE:  res_reg    <= cfg.data[15:0];
                    default: ;
                endcase
            end

            out_valid_reg <= out_valid_next;

            case (state_reg)
                S_IDLE:
                begin
                    if (tick_beat)
                    begin
                        phase_reg <= phase_next;
                        mult_reg  <= phase_next;
                        gate_reg  <= tick.gate;
                        k_reg     <= '0;
                        acc_reg   <= '0;
                        state_reg <= S_LOOK;
                    end
                end
                S_LOOK:
                begin
                    acc_reg  <= acc_next;
                    mult_reg <= mult_reg + {phase_reg[PHASE_WIDTH-2:0], 1'b0};
                    k_reg    <= k_reg + 1'b1;
                    if (k_reg == 2'd0)
                        s1_reg <= s_look;
                    if (k_reg == 2'd3)
                        state_reg <= S_DIV_GO;
                end
                S_DIV_GO:
                    state_reg <= S_DIV_WAIT;
                S_DIV_WAIT:
                begin
                    if (div_done)
                    begin
                        x_reg     <= x_next;
                        state_reg <= S_MR_GO;
                    end
                end
                S_MR_GO:
                    state_reg <= S_MR_WAIT;
                S_MR_WAIT:
                begin
                    if (mul_done)
                    begin
                        d_reg     <= d_next;
                        state_reg <= S_M1_GO;
                    end
                end
                S_M1_GO:
                    state_reg <= S_M1_WAIT;
                S_M1_WAIT:
                begin
                    if (mul_done)
                    begin
                        stage1_reg <= clamp(stage1_w + mul_p);
                        state_reg  <= S_M2_GO;
                    end
                end
                S_M2_GO:
                    state_reg <= S_M2_WAIT;
                S_M2_WAIT:
                begin
                    if (mul_done)
                    begin
                        stage2_reg <= clamp(stage2_w + mul_p);
                        state_reg  <= S_WB;
                    end
                end
                S_WB:
                begin
                    if (wb_fire)
                    begin
                        out_sine_reg  <= gate_reg ? s1_reg : '0;
                        // floor shift down to Q2.16 is the top 18 bits
                        out_sq_reg    <= gate_reg ? stage2_reg[SW-1:SW-18] : '0;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    assign tick.ready           = (state_reg == S_IDLE);
    assign cfg.ready            = 1'b1;
    assign result.valid         = out_valid_reg;
    assign result.sine_sample   = out_sine_reg;
    assign result.square_sample = out_sq_reg;

endmodule

>>> hdl/osc_lookup.sv
module osc_lookup #(
    parameter int TABLE_DEPTH = osc_pkg::TABLE_DEPTH_DEF,
    parameter int PHASE_WIDTH = osc_pkg::PHASE_WIDTH_DEF
) (
    input  logic [PHASE_WIDTH-1:0] phase,
    output logic signed [15:0]     sine
);

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int SC_W  = PHASE_WIDTH - 2 + IDX_W;

    typedef logic [TABLE_DEPTH-1:0][15:0] tbl_t;

    function automatic tbl_t build_table();
        tbl_t   t;
        longint x;
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            x    = (osc_pkg::HALF_PI_Q30 * longint'(i)) / TABLE_DEPTH;
            t[i] = osc_pkg::sine_q15(x);
        end
        return t;
    endfunction

    localparam tbl_t SINE_TABLE = build_table();

    logic [1:0]             quad;
    logic [PHASE_WIDTH-3:0] frac;
    logic [SC_W-1:0]        scaled;
    logic [IDX_W-1:0]       idx;
    logic [IDX_W:0]         mirror_full;
    logic [IDX_W-1:0]       mirror;
    logic [15:0]            mag;

    assign quad        = phase[PHASE_WIDTH-1:PHASE_WIDTH-2];
    assign frac        = phase[PHASE_WIDTH-3:0];
    assign scaled      = {{IDX_W{1'b0}}, frac} * SC_W'(TABLE_DEPTH);
    assign idx         = scaled[SC_W-1:PHASE_WIDTH-2];
    assign mirror_full = (IDX_W+1)'(TABLE_DEPTH) - {1'b0, idx};
    assign mirror      = mirror_full[IDX_W-1:0];

    // odd quadrants run the table backwards; index zero mirrors to full scale
    always_comb
    begin
        if (quad[0])
            mag = (idx == '0) ? 16'd32767 : SINE_TABLE[mirror];
        else
            mag = SINE_TABLE[idx];
    end

    assign sine = quad[1] ? -$signed(mag) : $signed(mag);

endmodule

>>> hdl/osc_div.sv
module osc_div #(
    parameter int NW = osc_pkg::STATE_WIDTH_DEF + 7
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [NW-1:0] num,
    output logic [NW-1:0] quot,
    output logic          done
);

    localparam int RW = osc_pkg::REM_W;
    localparam int CW = $clog2(NW);

    logic [NW-1:0] work_reg;
    logic [RW-1:0] rem_reg;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg;
    logic          done_reg;

    logic [RW+1:0] shifted;
    logic [RW+1:0] diff;
    logic          ge;

    // restoring division by the fixed divisor, one quotient bit per cycle;
    // quotient bits enter the numerator shifter from the bottom
    assign shifted = {1'b0, rem_reg, work_reg[NW-1]};
    assign diff    = shifted - (RW+2)'(osc_pkg::DIVISOR);
    assign ge      = !diff[RW+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CW'(NW-1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            work_reg <= num;
            rem_reg  <= '0;
        end
        else if (busy_reg)
        begin
            work_reg <= {work_reg[NW-2:0], ge};
            rem_reg  <= ge ? diff[RW-1:0] : shifted[RW-1:0];
        end
    end

    assign quot = work_reg;
    assign done = done_reg;

endmodule

>>> hdl/osc_sermul.sv
module osc_sermul #(
    parameter int WW = osc_pkg::STATE_WIDTH_DEF + 6
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  osc_pkg::mul_cmd_t    cmd,
    input  logic signed [WW-1:0] a,
    input  logic [15:0]          b,
    output logic signed [WW-1:0] p,
    output logic                 done
);

    localparam int PRW = WW + 16;

    logic [WW-1:0]  mag_reg;
    logic [15:0]    b_reg;
    logic [PRW-1:0] prod_reg;
    logic           neg_reg;
    logic           sh14_reg;
    logic [3:0]     cnt_reg;
    logic           busy_reg;
    logic           done_reg;

    logic [WW-1:0]  a_mag;
    logic [PRW-1:0] prod_step;
    logic [WW-1:0]  shifted;

    assign a_mag     = a[WW-1] ? (~a + 1'b1) : a;
    // MSB-first shift-add, one multiplier bit per cycle
    assign prod_step = {prod_reg[PRW-2:0], 1'b0} + (b_reg[15] ? {16'b0, mag_reg} : '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (cmd.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == 4'd15)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            mag_reg  <= a_mag;
            b_reg    <= b;
            prod_reg <= '0;
            neg_reg  <= a[WW-1];
            sh14_reg <= cmd.shift14;
        end
        else if (busy_reg)
        begin
            prod_reg <= prod_step;
            b_reg    <= {b_reg[14:0], 1'b0};
        end
    end

    // magnitude truncates, so the signed result rounds toward zero
    assign shifted = sh14_reg ? prod_reg[WW+13:14] : prod_reg[WW+15:16];
    assign p       = neg_reg ? -$signed(shifted) : $signed(shifted);
    assign done    = done_reg;

endmodule

>>> hdl/osc_check.sv
module osc_check (
    input logic               clk,
    input logic               rst_n,
    input logic               tick_valid,
    input logic               tick_ready,
    input logic               result_valid,
    input logic               result_ready,
    input logic signed [15:0] sine_sample,
    input logic signed [17:0] square_sample
);

    // a waiting result beat holds its payload
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(sine_sample)
            && $stable(square_sample))
        else $error("result beat changed while stalled");

    // one tick in flight at a time
    a_busy_after_tick: assert property (@(posedge clk) disable iff (!rst_n)
        tick_valid && tick_ready |=> !tick_ready)
        else $error("tick taken while busy");

    // a new result comes only out of a busy cycle
    a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(!tick_ready))
        else $error("result appeared without work");

    // sine peaks at +-32767, never the most negative code
    a_sine_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> sine_sample != 16'sh8000)
        else $error("sine out of range");

endmodule

bind oscillator_with_resonant_lowpass osc_check u_osc_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .tick_valid    (tick.valid),
    .tick_ready    (tick.ready),
    .result_valid  (result.valid),
    .result_ready  (result.ready),
    .sine_sample   (result.sine_sample),
    .square_sample (result.square_sample)
);

>>> sim/tb_oscillator_with_resonant_lowpass.sv
module tb_oscillator_with_resonant_lowpass;

    typedef struct {
        logic signed [15:0] sine;
        logic signed [17:0] square;
    } sample_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    osc_tick_if   tick_if ();
    osc_result_if res_if ();
    osc_cfg_if    cfg_if ();

    oscillator_with_resonant_lowpass u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .tick   (tick_if.sink),
        .result (res_if.source),
        .cfg    (cfg_if.sink)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // predictor state and register copies
    logic [31:0] step_reg;
    logic [15:0] cutoff_reg;
    logic [15:0] reso_reg;
    logic [31:0] phase;
    longint      lp_one;
    longint      lp_two;
    int          quarter_sine [256];

    sample_t     pending_samples [$];
    int          mismatches = 0;
    bit          tx_idle_on = 1'b1;
    bit          rx_idle_on = 1'b1;
    int          rx_hold = 0;

    task automatic build_quarter_sine();
        longint x;
        longint term;
        longint sum;
        longint v;
        for (int i = 0; i < 256; i++)
        begin
            x = (osc_pkg::HALF_PI_Q30 * i) / 256;
            term = x;
            sum = x;
            for (int k = 1; k <= 7; k++)
            begin
                term = (term * x) >>> 30;
                term = (term * x) >>> 30;
                term = term / ((2 * k) * (2 * k + 1));
                sum = (k % 2 == 1) ? sum - term : sum + term;
            end
            if (sum < 0)
                sum = 0;
            v = (sum * 32767 + (64'sd1 <<< 29)) >>> 30;
            if (v > 32767)
                v = 32767;
            quarter_sine[i] = int'(v);
        end
    endtask

    function automatic int sine_lookup(logic [31:0] ph);
        logic [7:0] idx;
        int v;
        idx = ph[29:22];
        if (ph[30])
            v = (idx == 8'd0) ? 32767 : quarter_sine[256 - idx];
        else
            v = quarter_sine[idx];
        return ph[31] ? -v : v;
    endfunction

    // (a * b) >> sh with truncation toward zero
    function automatic longint coef_mul(longint a, longint b, int sh);
        longint m;
        longint p;
        m = (a < 0) ? -a : a;
        p = (m * b) >>> sh;
        return (a < 0) ? -p : p;
    endfunction

    function automatic longint clamp32(longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    task automatic reset_model();
        step_reg = osc_pkg::PHASE_STEP_RST;
        cutoff_reg = '0;
        reso_reg = '0;
        phase = '0;
        lp_one = 0;
        lp_two = 0;
    endtask

    task automatic predict_sample(bit g);
        logic [31:0] p3;
        logic [31:0] p5;
        logic [31:0] p7;
        longint s1;
        longint harm;
        longint mag;
        longint x;
        longint d;
        longint sq;
        sample_t exp_s;
        phase = phase + step_reg;
        p3 = phase * 32'd3;
        p5 = phase * 32'd5;
        p7 = phase * 32'd7;
        s1 = sine_lookup(phase);
        harm = s1 * 105 + sine_lookup(p3) * 35 + sine_lookup(p5) * 21
             + sine_lookup(p7) * 15;
        mag = (((((harm < 0) ? -harm : harm) * 4) <<< 13) + 262) / 525;
        x = (harm < 0) ? -mag : mag;
        d = x - lp_one + coef_mul(lp_one - lp_two, reso_reg, 14);
        lp_one = clamp32(lp_one + coef_mul(d, cutoff_reg, 16));
        lp_two = clamp32(lp_two + coef_mul(lp_one - lp_two, cutoff_reg, 16));
        sq = lp_two >>> 14;
        if (sq > 131071)
            sq = 131071;
        if (sq < -131072)
            sq = -131072;
        exp_s.sine = g ? s1[15:0] : '0;
        exp_s.square = g ? sq[17:0] : '0;
        pending_samples.push_back(exp_s);
    endtask

    // result checker
    always @(posedge clk)
    begin
        if (rst_n && res_if.valid && res_if.ready)
        begin
            if (pending_samples.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result beat sine=%0d square=%0d",
                             res_if.sine_sample, res_if.square_sample);
            end
            else
            begin
                sample_t e;
                e = pending_samples.pop_front();
                if (e.sine !== res_if.sine_sample || e.square !== res_if.square_sample)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: sine exp %0d got %0d, square exp %0d got %0d",
                                 e.sine, res_if.sine_sample, e.square,
                                 res_if.square_sample);
                end
            end
        end
    end

    // result ready, with a long hold-off counted here
    always @(posedge clk)
    begin
        if (rx_hold > 0)
        begin
            res_if.ready <= 1'b0;
            rx_hold <= rx_hold - 1;
        end
        else if (!rx_idle_on)
            res_if.ready <= 1'b1;
        else
            res_if.ready <= ($urandom_range(99) >= 36);
    end

    task automatic send_tick(bit g);
        tick_if.valid <= 1'b1;
        tick_if.gate <= g;
        do
            @(posedge clk);
        while (!tick_if.ready);
        predict_sample(g);
        if (tx_idle_on && $urandom_range(99) < 36)
        begin
            tick_if.valid <= 1'b0;
            repeat ($urandom_range(4, 1)) @(posedge clk);
        end
    endtask

    task automatic drain();
        tick_if.valid <= 1'b0;
        @(posedge clk);
        while (pending_samples.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(osc_pkg::cfg_reg_t idx, logic [31:0] val);
        drain();
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data <= val;
        do
            @(posedge clk);
        while (!cfg_if.ready);
        cfg_if.valid <= 1'b0;
        case (idx)
            osc_pkg::REG_PHASE_STEP: step_reg = val;
            osc_pkg::REG_CUTOFF:     cutoff_reg = val[15:0];
            osc_pkg::REG_RESONANCE:  reso_reg = val[15:0];
            default: ;
        endcase
    endtask

    task automatic test_directed();
        send_tick(1'b1);
        send_tick(1'b0);
        send_tick(1'b1);
        write_reg(osc_pkg::REG_PHASE_STEP, 32'h8000_0000);
        write_reg(osc_pkg::REG_CUTOFF, 16'hFFFF);
        send_tick(1'b1);
        send_tick(1'b1);
        send_tick(1'b0);
        write_reg(osc_pkg::REG_PHASE_STEP, 32'd0);
        send_tick(1'b1);
        send_tick(1'b1);
        write_reg(osc_pkg::REG_PHASE_STEP, 32'hFFFF_FFFF);
        write_reg(osc_pkg::REG_RESONANCE, 16'd32768);
        repeat (4) send_tick(1'b1);
        write_reg(osc_pkg::REG_RESONANCE, 16'hFFFF);
        repeat (6) send_tick(1'b1);
        send_tick(1'b0);
        write_reg(osc_pkg::REG_CUTOFF, 16'd0);
        write_reg(osc_pkg::REG_RESONANCE, 16'd0);
        repeat (3) send_tick(1'b1);
    endtask

    task automatic random_settings();
        case ($urandom_range(3))
            0: write_reg(osc_pkg::REG_PHASE_STEP, $urandom);
            1: write_reg(osc_pkg::REG_PHASE_STEP, $urandom_range(32'h8000_0000));
            2: write_reg(osc_pkg::REG_PHASE_STEP, $urandom_range(32'h0100_0000));
            default: write_reg(osc_pkg::REG_PHASE_STEP,
                               ($urandom_range(1)) ? 32'h8000_0000 : 32'd1);
        endcase
        write_reg(osc_pkg::REG_CUTOFF,
                  ($urandom_range(3) == 0) ? 16'hFFFF : $urandom_range(65535));
        case ($urandom_range(3))
            0: write_reg(osc_pkg::REG_RESONANCE, 16'd0);
            1: write_reg(osc_pkg::REG_RESONANCE, 16'd32768);
            2: write_reg(osc_pkg::REG_RESONANCE, $urandom_range(65535));
            default: write_reg(osc_pkg::REG_RESONANCE, $urandom_range(32768));
        endcase
    endtask

    task automatic test_random(int n);
        random_settings();
        repeat (n) send_tick($urandom_range(99) < 80);
    endtask

    task automatic test_no_idle();
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        test_random(250);
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
    endtask

    // receiver stalls long while ticks keep coming
    task automatic test_backpressure();
        random_settings();
        rx_hold = 600;
        repeat (10) send_tick($urandom_range(1));
        drain();
        repeat (20) send_tick($urandom_range(1));
    endtask

    initial
    begin
        tick_if.valid = 1'b0;
        tick_if.gate = 1'b0;
        cfg_if.valid = 1'b0;
        cfg_if.index = osc_pkg::REG_PHASE_STEP;
        cfg_if.data = '0;
        res_if.ready = 1'b0;
        build_quarter_sine();
        reset_model();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        repeat (5) test_random(250);
        test_no_idle();
        test_backpressure();
        test_random(200);
        drain();
        repeat (150) @(posedge clk);
        if (mismatches == 0 && pending_samples.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    initial
    begin
        #20000000;
        $display("FAILURE");
        $finish;
    end

endmodule

>>> sim.f
hdl/osc_pkg.sv
hdl/osc_ifs.sv
hdl/osc_lookup.sv
hdl/osc_div.sv
hdl/osc_sermul.sv
hdl/oscillator_with_resonant_lowpass.sv
hdl/osc_check.sv
sim/tb_oscillator_with_resonant_lowpass.sv
